### rtl/qtflip_pkg.sv
// Shared types, codes and helpers for the quadtree pixel-flip node counter.
// No dependencies; imported by every module of the block but qtflip_ram.
package qtflip_pkg;

    // Default for the largest supported image order (side = 2^order).
    localparam int MAX_ORDER_DEF = 8;
    // Order selected after reset, clipped to the built maximum.
    localparam int ORDER_RESET = 8;

    typedef logic [1:0] stat_t;

    // Region status codes.
    localparam stat_t STAT_WHITE = 2'd0;
    localparam stat_t STAT_BLACK = 2'd1;
    localparam stat_t STAT_SPLIT = 2'd2;

    // One status word holds the four child slots of one region.
    typedef logic [7:0] quad_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic clr_init;   // restart the clearing sweep
        logic clr_step;   // clear one word, advance sweep address
        logic load;       // capture a pixel beat, start the walk at level 1
        logic lvl_wr;     // write back the updated word, step up one level
    } dp_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic clr_last;   // sweep at its last word
        logic lvl_last;   // current level is the top of the image
    } dp_stat_t;

    // Number of regions of side 2 or more in a 2^m square.
    function automatic int region_count(input int m);
        return ((4 ** m) - 1) / 3;
    endfunction

    // Status of a region from its four children.
    function automatic stat_t quad_status(input quad_t q);
        stat_t s;
        s = q[1:0];
        if (s != STAT_SPLIT && q[3:2] == s && q[5:4] == s && q[7:6] == s)
            return s;
        return STAT_SPLIT;
    endfunction

endpackage

### rtl/qtflip_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module qtflip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### rtl/qtflip_ctrl.sv
// Sequencer for clearing sweep and the per-level read/write walk.
// Depends on qtflip_pkg.
module qtflip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cfg_we,
    input  qtflip_pkg::dp_stat_t stat,
    output qtflip_pkg::dp_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import qtflip_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_RD:
                state_next = S_WR;   // read data lands next cycle
            S_WR:
            begin
                cmd.lvl_wr = 1'b1;
                state_next = stat.lvl_last ? S_DONE : S_RD;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        // new order: restart the sweep from word zero
        if (cfg_we)
        begin
            cmd.clr_init = 1'b1;
            cmd.clr_step = 1'b0;
            cmd.load     = 1'b0;
            cmd.lvl_wr   = 1'b0;
            state_next   = S_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

### rtl/qtflip_dp.sv
// Datapath: order register, walk registers, status RAM and split counter.
// Depends on qtflip_pkg and qtflip_ram.
module qtflip_dp #(
    parameter int MAX_ORDER = qtflip_pkg::MAX_ORDER_DEF,
    parameter int RC        = qtflip_pkg::region_count(MAX_ORDER),
    parameter int CW        = $clog2(RC + 1),
    parameter int AW        = (RC > 1) ? $clog2(RC) : 1,
    parameter int LW        = $clog2(MAX_ORDER + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_data,
    input  logic [7:0]           pixel_row,
    input  logic [7:0]           pixel_col,
    input  qtflip_pkg::dp_cmd_t  cmd,
    output qtflip_pkg::dp_stat_t stat,
    output logic [CW-1:0]        split_count
);
    import qtflip_pkg::*;

    localparam int M   = MAX_ORDER;
    localparam int EXT = M + 8;
    localparam logic [LW-1:0] ORDER_RST = LW'((ORDER_RESET > M) ? M : ORDER_RESET);
    localparam logic [LW-1:0] ORDER_MAX = LW'(M);
    localparam logic [CW-1:0] SPAN_TOP  = CW'(4 ** (M - 1));
    localparam logic [CW-1:0] CLR_LAST  = CW'(RC - 1);

    logic [LW-1:0] order_reg;
    logic [M-1:0]  rs_reg, cs_reg;
    logic [LW-1:0] lvl_reg, sh_reg;
    logic [CW-1:0] base_reg, span_reg;
    stat_t         child_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] clr_reg;

    logic [LW-1:0] order_sat;
    logic [M-1:0]  row_m, col_m;
    logic [EXT-1:0] row_ext, col_ext;
    logic [CW-1:0] reg_idx, addr_full;
    logic [1:0]    slot;
    quad_t         rdata, wword;
    stat_t         old_slot, new_slot, old_st, new_st;
    logic          ram_we;

    // saturate a written order into 1..MAX_ORDER
    always_comb
    begin
        if (cfg_data == 4'd0)
            order_sat = LW'(1);
        else if (32'(cfg_data) > M)
            order_sat = ORDER_MAX;
        else
            order_sat = LW'(cfg_data);
    end

    // drop coordinate bits at or above the order
    assign row_ext = EXT'(pixel_row);
    assign col_ext = EXT'(pixel_col);
    always_comb
    begin
        for (int i = 0; i < M; i++)
        begin
            row_m[i] = row_ext[i] & (LW'(i) < order_reg);
            col_m[i] = col_ext[i] & (LW'(i) < order_reg);
        end
    end

    // region index at the current level: row-major over a 2^sh side
    assign reg_idx   = (CW'(rs_reg >> 1) << sh_reg) | CW'(cs_reg >> 1);
    assign addr_full = cmd.clr_step ? clr_reg : (base_reg + reg_idx);
    assign slot      = {rs_reg[0], cs_reg[0]};

    always_comb
    begin
        old_slot = rdata[2*slot +: 2];
        // level 1 slots hold pixels: toggle; above, take the child's new status
        new_slot = (lvl_reg == LW'(1)) ? {1'b0, ~old_slot[0]} : child_reg;
        wword    = rdata;
        wword[2*slot +: 2] = new_slot;
        old_st   = quad_status(rdata);
        new_st   = quad_status(wword);
    end

    assign ram_we = cmd.clr_step | cmd.lvl_wr;

    qtflip_ram #(
        .WIDTH (8),
        .DEPTH (RC),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_full[AW-1:0]),
        .wdata (cmd.clr_step ? quad_t'(0) : wword),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RST;
            count_reg <= '0;
            clr_reg   <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                order_reg <= order_sat;
            if (cmd.clr_init)
            begin
                clr_reg   <= '0;
                count_reg <= '0;
            end
            else if (cmd.clr_step)
                clr_reg <= clr_reg + CW'(1);
            if (cmd.load)
                lvl_reg <= LW'(1);
            else if (cmd.lvl_wr)
            begin
                lvl_reg <= lvl_reg + LW'(1);
                if (new_st == STAT_SPLIT && old_st != STAT_SPLIT)
                    count_reg <= count_reg + CW'(1);
                else if (new_st != STAT_SPLIT && old_st == STAT_SPLIT)
                    count_reg <= count_reg - CW'(1);
            end
        end
    end

    // walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rs_reg    <= row_m;
            cs_reg    <= col_m;
            sh_reg    <= LW'(M - 1);
            base_reg  <= '0;
            span_reg  <= SPAN_TOP;
            child_reg <= STAT_WHITE;
        end
        else if (cmd.lvl_wr)
        begin
            rs_reg    <= rs_reg >> 1;
            cs_reg    <= cs_reg >> 1;
            sh_reg    <= sh_reg - LW'(1);
            base_reg  <= base_reg + span_reg;
            span_reg  <= span_reg >> 2;
            child_reg <= new_st;
        end
    end

    assign stat.clr_last = (clr_reg == CLR_LAST);
    assign stat.lvl_last = (lvl_reg == order_reg);
    assign split_count   = count_reg;

endmodule

### rtl/quadtree_pixel_flip_node_count.sv
// Top level of the quadtree pixel-flip node counter.
// Depends on qtflip_pkg, qtflip_ctrl, qtflip_dp (and qtflip_ram below it).
//
// Usage: the block keeps a 2^order square black/white image (all white after
// reset) and its region quadtree. A beat is taken when start is high and busy
// is low; it toggles pixel (pixel_row, pixel_col), coordinate bits at or above
// the order being ignored. The node count after the flip appears on
// node_count for exactly one cycle with done high; the receiver cannot stall,
// so it must take the result in that cycle. Each flip does one read and one
// write-back of the status RAM per quadtree level through the single RAM
// port and keeps busy high until its result is out. After reset, and after
// any write of grid_order, a clearing sweep with busy high writes each of the
// (4^MAX_ORDER - 1)/3 status words once; a grid_order write always starts a
// new, empty image. grid_order values of 0 read as 1, values above MAX_ORDER
// as MAX_ORDER.
module quadtree_pixel_flip_node_count #(
    parameter int MAX_ORDER = qtflip_pkg::MAX_ORDER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        grid_order_we,
    input  logic [3:0]  grid_order,
    // command beat
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel_row,
    input  logic [7:0]  pixel_col,
    // result beat
    output logic        done,
    output logic [16:0] node_count
);
    import qtflip_pkg::*;

    localparam int RC = region_count(MAX_ORDER);
    localparam int CW = $clog2(RC + 1);

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [CW-1:0] split_count;
    logic [CW+1:0] nodes;

    // Status RAM word = four 2-bit child slots of one region. A region's own
    // status is recomputed from its word, so one read-modify-write per level
    // gives both old and new status for the split count.
    qtflip_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (grid_order_we),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    qtflip_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (grid_order_we),
        .cfg_data    (grid_order),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .cmd         (cmd),
        .stat        (stat),
        .split_count (split_count)
    );

    // nodes = 1 + 4 * split regions, kept to the 17-bit result field
    assign nodes      = {split_count, 2'b01};
    assign node_count = 17'(nodes);

endmodule

### test/quadtree_pixel_flip_node_count_tb.sv
// Self-checking testbench for quadtree_pixel_flip_node_count.
// Depends on qtflip_pkg and the block's RTL; a scoreboard class predicts the
// node count of every accepted flip and checks each done beat against it.
`timescale 1ns / 1ps

module quadtree_pixel_flip_node_count_tb;

    import qtflip_pkg::*;

    localparam int MAXO        = MAX_ORDER_DEF;
    localparam int PIX_N       = 1 << (2 * MAXO);
    localparam int REGION_N    = ((1 << (2 * MAXO)) - 1) / 3;
    localparam int STALL_LIMIT = 100000;   // covers the clearing sweep
    localparam int ITEM_LAT    = 2 * MAXO + 8;

    // Shadow image plus region statuses; predicts the count after each flip.
    class quadtree_scoreboard;
        bit          pix_img [PIX_N];
        stat_t       region_st [REGION_N];
        int          level_base [MAXO + 1];
        int          split_n;
        int          order;
        int          errors;
        logic [16:0] expected_counts [$];

        function new();
            level_base[0] = 0;
            level_base[1] = 0;
            for (int l = 1; l < MAXO; l++)
                level_base[l + 1] = level_base[l] + (1 << (2 * (MAXO - l)));
            order  = (ORDER_RESET > MAXO) ? MAXO : ORDER_RESET;
            errors = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (pix_img[i]) pix_img[i] = 1'b0;
            foreach (region_st[i]) region_st[i] = STAT_WHITE;
            split_n = 0;
        endfunction

        // Any write saturates into 1..MAXO and starts an empty image.
        function void set_order(logic [3:0] v);
            if (v == 0)
                order = 1;
            else if (v > MAXO)
                order = MAXO;
            else
                order = v;
            clear_image();
        endfunction

        function void note_flip(logic [7:0] r, logic [7:0] c);
            int    row, col, y, x, ridx;
            stat_t q [4];
            stat_t nst;
            row = r & ((1 << order) - 1);
            col = c & ((1 << order) - 1);
            pix_img[(row << MAXO) | col] ^= 1'b1;
            for (int l = 1; l <= order; l++)
            begin
                // four children of the ancestor at level l, read at level l-1
                for (int k = 0; k < 4; k++)
                begin
                    y = ((row >> l) << 1) + k / 2;
                    x = ((col >> l) << 1) + k % 2;
                    if (l == 1)
                        q[k] = {1'b0, pix_img[(y << MAXO) | x]};
                    else
                        q[k] = region_st[level_base[l - 1] + y * (1 << (MAXO - l + 1)) + x];
                end
                if (q[0] != STAT_SPLIT && q[1] == q[0] && q[2] == q[0] && q[3] == q[0])
                    nst = q[0];
                else
                    nst = STAT_SPLIT;
                ridx = level_base[l] + (row >> l) * (1 << (MAXO - l)) + (col >> l);
                if (region_st[ridx] == STAT_SPLIT && nst != STAT_SPLIT)
                    split_n--;
                else if (region_st[ridx] != STAT_SPLIT && nst == STAT_SPLIT)
                    split_n++;
                region_st[ridx] = nst;
            end
            expected_counts.push_back(17'(1 + 4 * split_n));
        endfunction

        function void check_count(logic [16:0] got);
            logic [16:0] want;
            if (expected_counts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("node_count %0d with no flip outstanding", got);
                return;
            end
            want = expected_counts.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("node_count mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        grid_order_we;
    logic [3:0]  grid_order;
    logic        start;
    logic        busy;
    logic [7:0]  pixel_row;
    logic [7:0]  pixel_col;
    logic        done;
    logic [16:0] node_count;

    quadtree_scoreboard qt_model;
    bit gaps_on;       // random sender gaps enabled
    int idle_cycles;   // cycles since the last accepted command or result beat

    quadtree_pixel_flip_node_count u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid_order_we (grid_order_we),
        .grid_order    (grid_order),
        .start         (start),
        .busy          (busy),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .done          (done),
        .node_count    (node_count)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: done is a one-cycle strobe, no back-pressure possible.
    always @(posedge clk)
    begin
        if (rst_n && done)
            qt_model.check_count(node_count);
    end

    // Watchdog: any accepted command or result beat rearms it. The limit
    // covers the clearing sweep after reset and after each order write.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("quadtree_pixel_flip_node_count test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One command beat. Optional random gap first, taken once the block is
    // idle so it really holds the block off; otherwise start stays high back
    // to back. Inputs move on the falling edge, busy is sampled on the
    // rising edge.
    task automatic send_flip(input logic [7:0] r, input logic [7:0] c);
        int idle_n;
        if (gaps_on && $urandom_range(0, 99) < 12)
        begin
            idle_n = $urandom_range(1, 24);
            @(negedge clk);
            start <= 1'b0;
            while (busy) @(negedge clk);
            repeat (idle_n - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        pixel_row <= r;
        pixel_col <= c;
        do @(posedge clk); while (busy);
        qt_model.note_flip(r, c);
    endtask

    // Drain: drop start, wait for every outstanding count, let the walk
    // settle, then wait for busy low (also covers a clearing sweep).
    task automatic wait_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (qt_model.pending() != 0) @(posedge clk);
        repeat (ITEM_LAT) @(posedge clk);
        do @(posedge clk); while (busy);
    endtask

    // Order write only from idle; the block then clears itself.
    task automatic write_order(input logic [3:0] v);
        wait_quiet();
        @(negedge clk);
        grid_order_we <= 1'b1;
        grid_order    <= v;
        @(posedge clk);
        qt_model.set_order(v);
        @(negedge clk);
        grid_order_we <= 1'b0;
    endtask

    // Random flips, mostly structured so regions actually fill and merge:
    // whole aligned blocks filled (and often emptied again), clustered
    // toggles in a 4x4 window, and some scattered noise. High coordinate
    // bits stay random so the wrap above the order is always exercised.
    // Block size shrinks near the end so the beat count stays close to n.
    task automatic run_random(input int n);
        int         sent, mode, k, side, kmax;
        logic [7:0] br, bc;
        sent = 0;
        kmax = (qt_model.order < 3) ? qt_model.order : 3;
        while (sent < n)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
            begin
                send_flip(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end
            else if (mode < 7)
            begin
                k    = $urandom_range(1, kmax);
                while (k > 1 && (1 << (2 * k)) > n - sent)
                    k--;
                side = 1 << k;
                br   = 8'($urandom_range(0, 255)) & ~8'(side - 1);
                bc   = 8'($urandom_range(0, 255)) & ~8'(side - 1);
                for (int i = 0; i < side * side; i++)
                    send_flip(br + 8'(i / side), bc + 8'(i % side));
                sent += side * side;
                if ($urandom_range(0, 1) && side * side <= n - sent)
                begin
                    // empty it again in reverse, splitting back down
                    for (int i = side * side - 1; i >= 0; i--)
                        send_flip(br + 8'(i / side), bc + 8'(i % side));
                    sent += side * side;
                end
            end
            else
            begin
                br = 8'($urandom_range(0, 255)) & 8'hFC;
                bc = 8'($urandom_range(0, 255)) & 8'hFC;
                for (int i = 0; i < 4; i++)
                    send_flip(br + 8'($urandom_range(0, 3)), bc + 8'($urandom_range(0, 3)));
                sent += 4;
            end
            // now and then let the pipe run dry before continuing
            if ($urandom_range(0, 19) == 0)
                wait_quiet();
        end
    endtask

    initial
    begin
        qt_model      = new();
        gaps_on       = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        grid_order_we = 1'b0;
        grid_order    = 4'd8;
        pixel_row     = 8'd0;
        pixel_col     = 8'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset order (8): corners, a single pixel and its undo,
        // 2x2 merges at both corners, alternating bit patterns.
        send_flip(8'd0, 8'd0);
        send_flip(8'd0, 8'd0);
        send_flip(8'd255, 8'd255);
        send_flip(8'd255, 8'd0);
        send_flip(8'd0, 8'd255);
        send_flip(8'd0, 8'd0);
        send_flip(8'd0, 8'd1);
        send_flip(8'd1, 8'd0);
        send_flip(8'd1, 8'd1);
        send_flip(8'h55, 8'hAA);
        send_flip(8'hAA, 8'h55);
        send_flip(8'd254, 8'd254);
        send_flip(8'd254, 8'd255);
        send_flip(8'd255, 8'd254);
        wait_quiet();
        run_random(120);

        // Order 0 saturates to 1: whole image goes black then wraps.
        write_order(4'd0);
        send_flip(8'd0, 8'd0);
        send_flip(8'd0, 8'd1);
        send_flip(8'd1, 8'd0);
        send_flip(8'd1, 8'd1);
        send_flip(8'd3, 8'd2);
        send_flip(8'd255, 8'd254);
        run_random(40);

        // Order 15 saturates to max; this phase runs with no sender gaps.
        write_order(4'd15);
        gaps_on = 1'b0;
        run_random(100);
        gaps_on = 1'b1;

        // Order 3: coordinates wrap modulo 8.
        write_order(4'd3);
        send_flip(8'd8, 8'd8);
        send_flip(8'd0, 8'd0);
        send_flip(8'hF7, 8'h0F);
        run_random(80);

        write_order(4'd1);
        run_random(40);
        write_order(4'd2);
        run_random(80);
        write_order(4'd5);
        run_random(80);
        write_order(4'd8);
        run_random(60);

        wait_quiet();
        repeat (ITEM_LAT) @(posedge clk);
        if (qt_model.errors == 0 && qt_model.pending() == 0)
            $display("quadtree_pixel_flip_node_count test passed");
        else
            $display("quadtree_pixel_flip_node_count test failed");
        $finish;
    end

endmodule
